### src/ray_box_entry_face_core_assert.svh
// assertion macros shared by the ray box entry face rtl
`ifndef RAY_BOX_ENTRY_FACE_CORE_ASSERT_SVH
`define RAY_BOX_ENTRY_FACE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define RBEF_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("rbef assertion failed");

// condition must never be true outside reset
`define RBEF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("rbef forbidden condition seen");

`else

`define RBEF_ASSERT(lbl, clk, rst_n, prop)
`define RBEF_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

### src/rbef_pkg.sv
// types, widths and face codes for the ray box entry face pipeline
package rbef_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int DIFF_W      = COORD_WIDTH + 1;
	localparam int PROD_W      = COORD_WIDTH + DIFF_W;
	localparam int COF_W       = PROD_W + 1;
	localparam int NUM_FIELDS  = 12;
	localparam int IN_W        = NUM_FIELDS * COORD_WIDTH;
	localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int FACE_W      = 3;
	localparam int OUT_TDATA_W = ((FACE_W + 7) / 8) * 8;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DIFF_W-1:0]      diff_t;
	typedef logic signed [PROD_W-1:0]      prod_t;
	typedef logic signed [COF_W-1:0]       cof_t;

	typedef enum logic [FACE_W-1:0] {
		FACE_MISS,
		FACE_A,
		FACE_B,
		FACE_C,
		FACE_D,
		FACE_E,
		FACE_F
	} face_t;

	// input item, origin_x in the lowest bits
	typedef struct packed {
		coord_t corner_lo_z;
		coord_t corner_lo_y;
		coord_t corner_lo_x;
		coord_t corner_hi_z;
		coord_t corner_hi_y;
		coord_t corner_hi_x;
		coord_t dir_z;
		coord_t dir_y;
		coord_t dir_x;
		coord_t origin_z;
		coord_t origin_y;
		coord_t origin_x;
	} in_item_t;

	// origin minus box corner per axis, 0 = upper corner, 7 = lower corner
	typedef struct packed {
		coord_t dir_x;
		coord_t dir_y;
		coord_t dir_z;
		diff_t  bx0;
		diff_t  bx7;
		diff_t  by0;
		diff_t  by7;
		diff_t  bz0;
		diff_t  bz7;
	} diff_set_t;

	// cross products of direction and corner offsets
	typedef struct packed {
		prod_t zx0;
		prod_t zx7;
		prod_t xz0;
		prod_t xz7;
		prod_t yz0;
		prod_t yz7;
		prod_t zy0;
		prod_t zy7;
		prod_t yx0;
		prod_t yx7;
		prod_t xy0;
		prod_t xy7;
	} prod_set_t;

	// edge orientation tests, one bit per box edge
	typedef struct packed {
		logic e01;
		logic e12;
		logic e23;
		logic e30;
		logic e67;
		logic e74;
		logic e45;
		logic e56;
		logic e36;
		logic e50;
		logic e14;
		logic e72;
	} edge_set_t;

endpackage

### src/rbef_diff_stage.sv
// stage 1: corner offsets of the ray origin
module rbef_diff_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rbef_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rbef_pkg::diff_set_t out_data
);

	logic                valid_s1;
	rbef_pkg::diff_set_t data_s1;
	rbef_pkg::diff_set_t data_d;

	always_comb begin
		data_d.dir_x = in_data.dir_x;
		data_d.dir_y = in_data.dir_y;
		data_d.dir_z = in_data.dir_z;
		data_d.bx0 = rbef_pkg::diff_t'(in_data.origin_x) - rbef_pkg::diff_t'(in_data.corner_hi_x);
		data_d.bx7 = rbef_pkg::diff_t'(in_data.origin_x) - rbef_pkg::diff_t'(in_data.corner_lo_x);
		data_d.by0 = rbef_pkg::diff_t'(in_data.origin_y) - rbef_pkg::diff_t'(in_data.corner_hi_y);
		data_d.by7 = rbef_pkg::diff_t'(in_data.origin_y) - rbef_pkg::diff_t'(in_data.corner_lo_y);
		data_d.bz0 = rbef_pkg::diff_t'(in_data.origin_z) - rbef_pkg::diff_t'(in_data.corner_hi_z);
		data_d.bz7 = rbef_pkg::diff_t'(in_data.origin_z) - rbef_pkg::diff_t'(in_data.corner_lo_z);
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

### src/rbef_mult_stage.sv
// stage 2: twelve signed products of direction and corner offset
module rbef_mult_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rbef_pkg::diff_set_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rbef_pkg::prod_set_t out_data
);

	logic                valid_s2;
	rbef_pkg::prod_set_t data_s2;
	rbef_pkg::prod_set_t data_d;

	// full width signed product, never rounded
	function automatic rbef_pkg::prod_t mul(rbef_pkg::coord_t a, rbef_pkg::diff_t b);
		rbef_pkg::prod_t pa;
		rbef_pkg::prod_t pb;
		pa = rbef_pkg::prod_t'(a);
		pb = rbef_pkg::prod_t'(b);
		return pa * pb;
	endfunction

	always_comb begin
		data_d.zx0 = mul(in_data.dir_z, in_data.bx0);
		data_d.zx7 = mul(in_data.dir_z, in_data.bx7);
		data_d.xz0 = mul(in_data.dir_x, in_data.bz0);
		data_d.xz7 = mul(in_data.dir_x, in_data.bz7);
		data_d.yz0 = mul(in_data.dir_y, in_data.bz0);
		data_d.yz7 = mul(in_data.dir_y, in_data.bz7);
		data_d.zy0 = mul(in_data.dir_z, in_data.by0);
		data_d.zy7 = mul(in_data.dir_z, in_data.by7);
		data_d.yx0 = mul(in_data.dir_y, in_data.bx0);
		data_d.yx7 = mul(in_data.dir_y, in_data.bx7);
		data_d.xy0 = mul(in_data.dir_x, in_data.by0);
		data_d.xy7 = mul(in_data.dir_x, in_data.by7);
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2 <= data_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

### src/rbef_edge_stage.sv
// stage 3: exact cofactor signs for the twelve box edges
module rbef_edge_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rbef_pkg::prod_set_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rbef_pkg::edge_set_t out_data
);

	logic                valid_s3;
	rbef_pkg::edge_set_t data_s3;
	rbef_pkg::edge_set_t data_d;

	// a - b > 0
	function automatic logic pos(rbef_pkg::prod_t a, rbef_pkg::prod_t b);
		rbef_pkg::cof_t c;
		c = rbef_pkg::cof_t'(a) - rbef_pkg::cof_t'(b);
		return !c[rbef_pkg::COF_W-1] && (c != '0);
	endfunction

	// a - b < 0
	function automatic logic neg(rbef_pkg::prod_t a, rbef_pkg::prod_t b);
		rbef_pkg::cof_t c;
		c = rbef_pkg::cof_t'(a) - rbef_pkg::cof_t'(b);
		return c[rbef_pkg::COF_W-1];
	endfunction

	// the ro-v+rd terms cancel, leaving dir x offset cross terms
	always_comb begin
		data_d.e01 = pos(in_data.zx0, in_data.xz0);
		data_d.e12 = pos(in_data.yz0, in_data.zy7);
		data_d.e23 = neg(in_data.zx7, in_data.xz0);
		data_d.e30 = neg(in_data.yz0, in_data.zy0);
		data_d.e67 = pos(in_data.zx7, in_data.xz7);
		data_d.e74 = neg(in_data.yz7, in_data.zy7);
		data_d.e45 = neg(in_data.zx0, in_data.xz7);
		data_d.e56 = pos(in_data.yz7, in_data.zy0);
		data_d.e36 = pos(in_data.yx7, in_data.xy0);
		data_d.e50 = neg(in_data.yx0, in_data.xy0);
		data_d.e14 = pos(in_data.yx0, in_data.xy7);
		data_d.e72 = neg(in_data.yx7, in_data.xy7);
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3 <= data_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

### src/rbef_face_stage.sv
// stage 4: face pattern match and output register
module rbef_face_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rbef_pkg::edge_set_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rbef_pkg::face_t     out_face
);

	logic            valid_s4;
	rbef_pkg::face_t face_s4;
	rbef_pkg::face_t face_d;

	always_comb begin
		priority if (in_data.e01 && in_data.e12 && in_data.e23 && in_data.e30) begin
			face_d = rbef_pkg::FACE_A;
		end else if (!in_data.e50 && !in_data.e30 && !in_data.e36 && !in_data.e56) begin
			face_d = rbef_pkg::FACE_B;
		end else if (in_data.e14 && !in_data.e01 && in_data.e50 && !in_data.e45) begin
			face_d = rbef_pkg::FACE_C;
		end else if (!in_data.e72 && !in_data.e12 && !in_data.e14 && !in_data.e74) begin
			face_d = rbef_pkg::FACE_D;
		end else if (in_data.e36 && !in_data.e23 && in_data.e72 && !in_data.e67) begin
			face_d = rbef_pkg::FACE_E;
		end else if (in_data.e45 && in_data.e56 && in_data.e67 && in_data.e74) begin
			face_d = rbef_pkg::FACE_F;
		end else begin
			face_d = rbef_pkg::FACE_MISS;
		end
	end

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			face_s4 <= face_d;
		end
	end

	assign out_valid = valid_s4;
	assign out_face  = face_s4;

endmodule

### src/ray_box_entry_face_core.sv
// top level of the ray box entry face classifier pipeline
//
// channel   | dir | payload
// s_axis    | in  | ray origin, ray direction, two box corners (12 x 24 bit signed)
// m_axis    | out | hit_face, 0 miss, 1..6 faces a..f
//
// four register stages: corner offsets, products, edge signs, face select
// the accept edge loads the first stage, then the item passes the product, edge
// sign and face registers in turn; one item per cycle sustained while m_axis_tready
// holds high, set by the one-item-per-stage pipeline registers
// each stage holds while the stage after it is full and stalled, so a stalled
// output backs up stage by stage and s_axis_tready drops only when all four are full
// arst_n clears the stage valid bits only; payload registers are not reset

`include "ray_box_entry_face_core_assert.svh"

module ray_box_entry_face_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
	// corner_hi_x, corner_hi_y, corner_hi_z, corner_lo_x, corner_lo_y, corner_lo_z
	input  logic [rbef_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// hit_face, zero filled above
	output logic [rbef_pkg::OUT_TDATA_W-1:0]      m_axis_tdata
);

	rbef_pkg::in_item_t  in_item;
	rbef_pkg::diff_set_t diff_data;
	rbef_pkg::prod_set_t prod_data;
	rbef_pkg::edge_set_t edge_data;
	rbef_pkg::face_t     face;

	logic diff_valid;
	logic diff_ready;
	logic prod_valid;
	logic prod_ready;
	logic edge_valid;
	logic edge_ready;

	// unpack the input item, first field in the low bits
	assign in_item = rbef_pkg::in_item_t'(s_axis_tdata[rbef_pkg::IN_W-1:0]);

	// offsets from the origin to both corners on each axis
	rbef_diff_stage u_diff (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (in_item),
		.out_valid (diff_valid),
		.out_ready (diff_ready),
		.out_data  (diff_data)
	);

	// direction times offset, full width
	rbef_mult_stage u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (diff_valid),
		.in_ready  (diff_ready),
		.in_data   (diff_data),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out_data  (prod_data)
	);

	// exact sign of each edge cofactor
	rbef_edge_stage u_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (prod_valid),
		.in_ready  (prod_ready),
		.in_data   (prod_data),
		.out_valid (edge_valid),
		.out_ready (edge_ready),
		.out_data  (edge_data)
	);

	// priority match a..f and the output register
	rbef_face_stage u_face (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (edge_valid),
		.in_ready  (edge_ready),
		.in_data   (edge_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_face  (face)
	);

	assign m_axis_tdata = rbef_pkg::OUT_TDATA_W'(face);

	// input backpressure only with every stage occupied
	`RBEF_ASSERT(a_full_when_blocked, clk, arst_n,
		!s_axis_tready |-> (diff_valid && prod_valid && edge_valid && m_axis_tvalid))

	// an accepted item lands in the first stage
	`RBEF_ASSERT(a_accept_fills_s1, clk, arst_n,
		(s_axis_tvalid && s_axis_tready) |=> diff_valid)

	// edge signs hold while the face stage is blocked
	`RBEF_ASSERT(a_edge_hold, clk, arst_n,
		(edge_valid && !edge_ready) |=> (edge_valid && $stable(edge_data)))

	// code seven never leaves the block
	`RBEF_ASSERT_NEVER(a_face_range, clk, arst_n,
		m_axis_tvalid && (m_axis_tdata[rbef_pkg::FACE_W-1:0] == 3'd7))

endmodule
